// ===== rtl/core/dfu_pkg.sv =====
// Shared types, codes and constants of the firmware-upgrade request engine.
`default_nettype none

package dfu_pkg;

   localparam int MODE_W = 4;
   localparam int BLK_W = 16;
   localparam int LEN_W = 16;
   localparam int BYTE_W = 8;
   localparam int REG_W = 16;
   localparam int OUT_ADDR_W = 16;
   localparam int XLEN_W = 7;
   localparam int STATE_W = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam int PAGE_SIZE = 512;
   localparam int PAGE_MASK = PAGE_SIZE - 1;

   localparam logic [MODE_W-1:0] MODE_DETACH    = 4'd0;
   localparam logic [MODE_W-1:0] MODE_DOWNLOAD  = 4'd1;
   localparam logic [MODE_W-1:0] MODE_UPLOAD    = 4'd2;
   localparam logic [MODE_W-1:0] MODE_GETSTATUS = 4'd3;
   localparam logic [MODE_W-1:0] MODE_CLRSTATUS = 4'd4;
   localparam logic [MODE_W-1:0] MODE_GETSTATE  = 4'd5;
   localparam logic [MODE_W-1:0] MODE_ABORT     = 4'd6;
   localparam logic [MODE_W-1:0] MODE_DATA      = 4'd7;

   localparam logic [STATE_W-1:0] STATE_IDLE   = 2'd0;
   localparam logic [STATE_W-1:0] STATE_DNIDLE = 2'd1;
   localparam logic [STATE_W-1:0] STATE_UPIDLE = 2'd2;
   localparam logic [STATE_W-1:0] STATE_ERROR  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ADDR = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNK  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_SIZE  = 1'b1;

   typedef enum logic [3:0] {
      PS_IDLE   = 4'b0001,
      PS_DNIDLE = 4'b0010,
      PS_UPIDLE = 4'b0100,
      PS_ERROR  = 4'b1000
   } proto_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  req_length;
      logic [BLK_W-1:0]  block_num;
      logic [MODE_W-1:0] mode;
   } req_item_type;

   typedef struct packed {
      logic                  download_done;
      logic [BYTE_W-1:0]     wr_data;
      logic                  do_write;
      logic                  do_erase;
      logic [XLEN_W-1:0]     xfer_len;
      logic [OUT_ADDR_W-1:0] addr;
      logic [STATUS_W-1:0]   status_out;
      logic [STATE_W-1:0]    state_out;
      logic                  ack;
   } rsp_item_type;

   function automatic logic [STATE_W-1:0] state_code(proto_state_type s);
      logic [STATE_W-1:0] code;
      case (s)
         PS_IDLE:   code = STATE_IDLE;
         PS_DNIDLE: code = STATE_DNIDLE;
         PS_UPIDLE: code = STATE_UPIDLE;
         PS_ERROR:  code = STATE_ERROR;
         default:   code = STATE_ERROR;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dfu_in_stage.sv =====
// Input register of the request engine: holds one request word until it is processed.
`default_nettype none

module dfu_in_stage (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // block_num, req_length, data_byte
   input  wire logic [dfu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  wire logic [dfu_pkg::MODE_W-1:0]       req_tuser,
   input  wire logic                             take,
   output logic                                  item_valid,
   output dfu_pkg::req_item_type                 item
);
   import dfu_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.mode       <= req_tuser;
         item_ff.block_num  <= req_tdata[15:0];
         item_ff.req_length <= req_tdata[31:16];
         item_ff.data_byte  <= req_tdata[39:32];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dfu_core.sv =====
// Protocol state, configuration registers and per-word request evaluation.
`default_nettype none

module dfu_core #(
   parameter int MAX_PACKET = 64,
   parameter int ADDR_WIDTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [dfu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [dfu_pkg::REG_W-1:0]          csr_wdata,
   input  wire logic                               step_en,
   input  wire dfu_pkg::req_item_type              item,
   output dfu_pkg::rsp_item_type                   result
);
   import dfu_pkg::*;

   localparam int CW = ((ADDR_WIDTH > 17) ? ADDR_WIDTH : 17) + 1;
   localparam logic [CW-1:0] AMASK_W = {{(CW - ADDR_WIDTH){1'b0}}, {ADDR_WIDTH{1'b1}}};
   localparam logic [CW-1:0] MAXP_W = CW'(MAX_PACKET);
   localparam logic [CW-1:0] PMASK_W = CW'(PAGE_MASK);

   logic [REG_W-1:0]      region_start_ff;
   logic [REG_W-1:0]      region_size_ff;
   proto_state_type       state_ff;
   proto_state_type       state_in;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [BLK_W-1:0]      expected_ff;
   logic [BLK_W-1:0]      expected_in;
   logic [ADDR_WIDTH-1:0] cursor_ff;
   logic [ADDR_WIDTH-1:0] cursor_in;
   logic [XLEN_W-1:0]     pending_ff;
   logic [XLEN_W-1:0]     pending_in;
   logic                  finished_ff;
   logic                  finished_in;

   logic [CW-1:0]         rs_w;
   logic [CW-1:0]         end_w;
   logic [CW-1:0]         cur_base;
   logic [CW-1:0]         cur_w;
   logic [CW-1:0]         len_w;
   logic [CW-1:0]         sum_w;
   logic [CW-1:0]         left_w;
   logic [CW-1:0]         addr_w;
   logic [BLK_W-1:0]      exp_base;
   logic [BLK_W-1:0]      prev_blk;
   logic                  is_idle;
   logic                  ack;
   logic [XLEN_W-1:0]     xlen;
   logic                  erase;
   logic                  write;
   logic [BYTE_W-1:0]     wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_size_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REGION_START: region_start_ff <= csr_wdata;
            CSR_REGION_SIZE:  region_size_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      rs_w     = CW'(region_start_ff);
      end_w    = rs_w + CW'(region_size_ff);
      is_idle  = (state_ff == PS_IDLE);
      cur_w    = CW'(cursor_ff);
      cur_base = is_idle ? (rs_w & AMASK_W) : cur_w;
      exp_base = is_idle ? item.block_num : expected_ff;
      prev_blk = expected_ff - BLK_W'(1);
      len_w    = CW'(item.req_length);
      sum_w    = cur_base + len_w;
      left_w   = end_w - cur_base;

      state_in    = state_ff;
      status_in   = status_ff;
      expected_in = expected_ff;
      cursor_in   = cursor_ff;
      pending_in  = (item.mode == MODE_DATA) ? pending_ff : '0;
      finished_in = finished_ff;
      ack         = 1'b0;
      addr_w      = '0;
      xlen        = '0;
      erase       = 1'b0;
      write       = 1'b0;
      wdata       = '0;

      case (item.mode) inside
         MODE_DETACH, MODE_GETSTATUS, MODE_GETSTATE: begin
            ack = 1'b1;
         end
         MODE_CLRSTATUS, MODE_ABORT: begin
            state_in  = PS_IDLE;
            status_in = STAT_OK;
            ack       = 1'b1;
         end
         MODE_DOWNLOAD: begin
            if (state_ff == PS_IDLE || state_ff == PS_DNIDLE) begin
               ack = 1'b1;
               if (is_idle) begin
                  expected_in = item.block_num;
                  cursor_in   = cur_base[ADDR_WIDTH-1:0];
               end
               if (is_idle || item.block_num != prev_blk) begin
                  if (item.block_num != exp_base) begin
                     state_in  = PS_ERROR;
                     status_in = STAT_UNK;
                  end else if (item.req_length == '0) begin
                     state_in    = PS_IDLE;
                     finished_in = 1'b1;
                  end else begin
                     expected_in = exp_base + BLK_W'(1);
                     if (cur_base < rs_w || sum_w > end_w) begin
                        state_in  = PS_ERROR;
                        status_in = STAT_ADDR;
                        ack       = 1'b0;
                     end else if (len_w > MAXP_W) begin
                        state_in  = PS_ERROR;
                        status_in = STAT_UNK;
                        ack       = 1'b0;
                     end else begin
                        pending_in = item.req_length[XLEN_W-1:0];
                        state_in   = PS_DNIDLE;
                     end
                  end
               end
            end
         end
         MODE_UPLOAD: begin
            if (state_ff == PS_IDLE || state_ff == PS_UPIDLE) begin
               ack = 1'b1;
               if (is_idle) begin
                  expected_in = item.block_num;
                  cursor_in   = cur_base[ADDR_WIDTH-1:0];
               end
               if ((!is_idle && item.block_num == prev_blk) ||
                   item.block_num != exp_base) begin
                  state_in  = PS_ERROR;
                  status_in = STAT_UNK;
               end else begin
                  expected_in = exp_base + BLK_W'(1);
                  if (cur_base < rs_w || cur_base > end_w) begin
                     state_in  = PS_ERROR;
                     status_in = STAT_ADDR;
                  end else if (len_w > MAXP_W) begin
                     state_in  = PS_ERROR;
                     status_in = STAT_UNK;
                  end else begin
                     addr_w = cur_base;
                     if (left_w < len_w) begin
                        xlen      = left_w[XLEN_W-1:0];
                        cursor_in = end_w[ADDR_WIDTH-1:0];
                        state_in  = PS_IDLE;
                     end else begin
                        xlen      = item.req_length[XLEN_W-1:0];
                        cursor_in = sum_w[ADDR_WIDTH-1:0];
                        state_in  = PS_UPIDLE;
                     end
                  end
               end
            end
         end
         MODE_DATA: begin
            if (pending_ff != '0) begin
               ack        = 1'b1;
               addr_w     = cur_w;
               write      = 1'b1;
               wdata      = item.data_byte;
               erase      = ((cur_w & PMASK_W) == '0);
               cursor_in  = cursor_ff + ADDR_WIDTH'(1);
               pending_in = pending_ff - XLEN_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= PS_IDLE;
         status_ff   <= STAT_OK;
         expected_ff <= '0;
         cursor_ff   <= '0;
         pending_ff  <= '0;
         finished_ff <= 1'b0;
      end else if (step_en) begin
         state_ff    <= state_in;
         status_ff   <= status_in;
         expected_ff <= expected_in;
         cursor_ff   <= cursor_in;
         pending_ff  <= pending_in;
         finished_ff <= finished_in;
      end
   end

   always_comb begin
      result.ack           = ack;
      result.state_out     = state_code(state_in);
      result.status_out    = status_in;
      result.addr          = addr_w[OUT_ADDR_W-1:0];
      result.xfer_len      = xlen;
      result.do_erase      = erase;
      result.do_write      = write;
      result.wr_data       = wdata;
      result.download_done = finished_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != PS_ERROR) |-> (status_ff == STAT_OK))
      else $error("status is not ok outside the error state");

   assert property (@(posedge clock) disable iff (reset)
      (step_en && pending_ff != '0 && item.mode == MODE_DATA) |=>
         (pending_ff == $past(pending_ff) - XLEN_W'(1)))
      else $error("pending byte count did not step down on a data byte");

endmodule

`default_nettype wire

// ===== rtl/core/dfu_out_stage.sv =====
// Result register of the request engine: holds one response word until it is taken.
`default_nettype none

module dfu_out_stage (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             load,
   input  wire dfu_pkg::rsp_item_type            result,
   output logic                                  free,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // ack, state_out, status_out, addr, xfer_len, do_erase, do_write, wr_data,
   // download_done, zero fill
   output logic [dfu_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import dfu_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = free ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_item_type)){1'b0}}, data_ff};

endmodule

`default_nettype wire

// ===== rtl/core/dfu_request_engine.sv =====
// An accepted word is presented as a response once it is loaded into the result register.
// Throughput: one request or data word per cycle, set by the single evaluation step between
// the input register and the result register; a stalled response stops input after one word.
// Reset is synchronous and active high; it clears the protocol state, the cursor,
// the block counter, the done flag, both region registers and both stage valid flags.
`default_nettype none

module dfu_request_engine #(
   parameter int MAX_PACKET = 64,
   parameter int ADDR_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [dfu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [dfu_pkg::REG_W-1:0]        csr_wdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // block_num, req_length, data_byte
   input  wire logic [dfu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  wire logic [dfu_pkg::MODE_W-1:0]       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // ack, state_out, status_out, addr, xfer_len, do_erase, do_write, wr_data,
   // download_done, zero fill
   output logic [dfu_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import dfu_pkg::*;

   logic         item_valid;
   logic         out_free;
   logic         advance;
   req_item_type item;
   rsp_item_type result;

   assign advance = item_valid && out_free;

   dfu_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   dfu_core #(
      .MAX_PACKET (MAX_PACKET),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_en   (advance),
      .item      (item),
      .result    (result)
   );

   dfu_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      (advance && result.do_erase) |-> (result.do_write && result.ack))
      else $error("erase command without an acknowledged write");

   assert property (@(posedge clock) disable iff (reset)
      (advance && result.xfer_len != '0) |->
         (result.ack && !result.do_write && result.xfer_len <= XLEN_W'(MAX_PACKET)))
      else $error("upload length without an acknowledged upload");

   assert property (@(posedge clock) disable iff (reset)
      (item_valid && !out_free) |=> (item_valid && $stable(item)))
      else $error("pending request word lost while the response stalled");

   assert property (@(posedge clock)
      $past(reset) |-> (!rsp_tvalid && req_tready))
      else $error("stages not empty after reset");

endmodule

`default_nettype wire

// ===== tb/tb_dfu_request_engine.sv =====
// Self-checking testbench of the firmware-upgrade request engine: directed and random streams.
module tb_dfu_request_engine;
   import dfu_pkg::*;

   localparam int MAX_PACKET = 64;
   localparam int RANDOM_WORDS = 600;
   localparam int RSP_BITS = $bits(rsp_item_type);
   localparam logic [MODE_W-1:0] MODE_UNKNOWN = 4'd8;
   localparam logic [MODE_W-1:0] MODE_LAST = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [REG_W-1:0] region_start;
   logic [REG_W-1:0] region_size;
   logic [STATE_W-1:0] dev_state;
   logic [STATUS_W-1:0] dev_status;
   logic [BLK_W-1:0] want_block;
   logic [OUT_ADDR_W-1:0] flash_cursor;
   logic [XLEN_W-1:0] bytes_owed;
   logic dl_done;

   rsp_item_type rsp_due[$];
   int fail_count = 0;
   int acked_words = 0;
   int stall_left = 0;
   logic idle_on = 1'b1;

   dfu_request_engine u_top (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void set_error(logic [STATUS_W-1:0] code);
      dev_state = STATE_ERROR;
      dev_status = code;
   endfunction

   function automatic rsp_item_type dfu_step(req_item_type w);
      rsp_item_type r;
      int region_end;
      int len;
      int left;
      logic [BLK_W-1:0] prev_blk;
      r = '0;
      region_end = int'(region_start) + int'(region_size);
      len = int'(w.req_length);
      prev_blk = want_block - 1'b1;
      if (w.mode != MODE_DATA) begin
         bytes_owed = '0;
      end
      case (w.mode) inside
         MODE_DETACH, MODE_GETSTATUS, MODE_GETSTATE: begin
            r.ack = 1'b1;
         end
         MODE_CLRSTATUS, MODE_ABORT: begin
            dev_state = STATE_IDLE;
            dev_status = STAT_OK;
            r.ack = 1'b1;
         end
         MODE_DOWNLOAD: begin
            if (dev_state == STATE_DNIDLE && w.block_num == prev_blk) begin
               r.ack = 1'b1;
            end else if (dev_state == STATE_IDLE || dev_state == STATE_DNIDLE) begin
               if (dev_state == STATE_IDLE) begin
                  want_block = w.block_num;
                  flash_cursor = region_start;
               end
               r.ack = 1'b1;
               if (w.block_num != want_block) begin
                  set_error(STAT_UNK);
               end else if (len == 0) begin
                  dev_state = STATE_IDLE;
                  dl_done = 1'b1;
               end else begin
                  want_block = want_block + 1'b1;
                  if (flash_cursor < region_start || int'(flash_cursor) + len > region_end) begin
                     set_error(STAT_ADDR);
                     r.ack = 1'b0;
                  end else if (len > MAX_PACKET) begin
                     set_error(STAT_UNK);
                     r.ack = 1'b0;
                  end else begin
                     bytes_owed = 7'(len);
                     dev_state = STATE_DNIDLE;
                  end
               end
            end
         end
         MODE_UPLOAD: begin
            if (dev_state == STATE_IDLE || dev_state == STATE_UPIDLE) begin
               r.ack = 1'b1;
               if (dev_state == STATE_UPIDLE && w.block_num == prev_blk) begin
                  set_error(STAT_UNK);
               end else begin
                  if (dev_state == STATE_IDLE) begin
                     want_block = w.block_num;
                     flash_cursor = region_start;
                  end
                  if (w.block_num != want_block) begin
                     set_error(STAT_UNK);
                  end else begin
                     want_block = want_block + 1'b1;
                     if (flash_cursor < region_start || int'(flash_cursor) > region_end) begin
                        set_error(STAT_ADDR);
                     end else if (len > MAX_PACKET) begin
                        set_error(STAT_UNK);
                     end else begin
                        left = region_end - int'(flash_cursor);
                        if (left < len) begin
                           len = left;
                           dev_state = STATE_IDLE;
                        end else begin
                           dev_state = STATE_UPIDLE;
                        end
                        r.addr = flash_cursor;
                        r.xfer_len = 7'(len);
                        flash_cursor = flash_cursor + 16'(len);
                     end
                  end
               end
            end
         end
         MODE_DATA: begin
            if (bytes_owed != 0) begin
               r.ack = 1'b1;
               r.addr = flash_cursor;
               r.do_write = 1'b1;
               r.wr_data = w.data_byte;
               r.do_erase = ((int'(flash_cursor) & PAGE_MASK) == 0);
               flash_cursor = flash_cursor + 1'b1;
               bytes_owed = bytes_owed - 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.state_out = dev_state;
      r.status_out = dev_status;
      r.download_done = dl_done;
      return r;
   endfunction

   function automatic logic [LEN_W-1:0] pick_length();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return 16'($urandom_range(MAX_PACKET + 1, 200));
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, MAX_PACKET));
      endcase
   endfunction

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
      end
   endtask

   task automatic check_rsp(input logic [RSP_DATA_W-1:0] word);
      rsp_item_type got;
      rsp_item_type want;
      got = word[RSP_BITS-1:0];
      if (rsp_due.size() == 0) begin
         report($sformatf("response word 0x%0h with none awaited", word));
         return;
      end
      want = rsp_due.pop_front();
      check_field("ack", int'(got.ack), int'(want.ack));
      check_field("state_out", int'(got.state_out), int'(want.state_out));
      check_field("status_out", int'(got.status_out), int'(want.status_out));
      check_field("addr", int'(got.addr), int'(want.addr));
      check_field("xfer_len", int'(got.xfer_len), int'(want.xfer_len));
      check_field("do_erase", int'(got.do_erase), int'(want.do_erase));
      check_field("do_write", int'(got.do_write), int'(want.do_write));
      check_field("wr_data", int'(got.wr_data), int'(want.wr_data));
      check_field("download_done", int'(got.download_done), int'(want.download_done));
      check_field("zero fill", int'(word[RSP_DATA_W-1:RSP_BITS]), 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_rsp(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 9);
         rsp_tready <= 1'b0;
      end
   end

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [BLK_W-1:0] blk,
                            input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data);
      req_item_type w;
      rsp_item_type predicted;
      w.mode = mode;
      w.block_num = blk;
      w.req_length = len;
      w.data_byte = data;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         if (req_tvalid) begin
            req_tvalid <= 1'b0;
         end
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {data, len, blk};
      predicted = dfu_step(w);
      rsp_due.push_back(predicted);
      if (predicted.ack) begin
         acked_words++;
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_responses();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
      end
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_region(input logic [REG_W-1:0] start, input logic [REG_W-1:0] size);
      drain_responses();
      csr_we <= 1'b1;
      csr_index <= CSR_REGION_START;
      csr_wdata <= start;
      @(posedge clock);
      region_start = start;
      csr_index <= CSR_REGION_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      region_size = size;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_idle_requests();
      write_region(16'h0000, 16'h0000);
      send_word(MODE_LAST, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_word(MODE_UNKNOWN, 16'h0000, 16'h0000, 8'h00);
      send_word(MODE_DATA, 16'h0000, 16'h0001, 8'hFF);
      send_word(MODE_DOWNLOAD, 16'h0005, 16'h0000, 8'h00);
      send_word(MODE_GETSTATE, 16'h1234, 16'h0040, 8'h5A);
   endtask

   task automatic test_download_blocks();
      write_region(16'h01FE, 16'h0100);
      send_word(MODE_DOWNLOAD, 16'hFFFF, 16'h0004, 8'h00);
      send_word(MODE_DATA, 16'h0000, 16'h0000, 8'h00);
      send_word(MODE_DATA, 16'h0000, 16'h0000, 8'hFF);
      send_word(MODE_DATA, 16'h0000, 16'h0000, 8'hA5);
      send_word(MODE_DOWNLOAD, 16'hFFFF, 16'h0004, 8'h00);
      send_word(MODE_DATA, 16'h0000, 16'h0000, 8'h5A);
      send_word(MODE_DOWNLOAD, 16'h0007, 16'h0004, 8'h00);
      send_word(MODE_UPLOAD, 16'h0000, 16'h0001, 8'h00);
      send_word(MODE_CLRSTATUS, 16'h0000, 16'h0000, 8'h00);
   endtask

   task automatic test_upload_and_limits();
      write_region(16'h1000, 16'h0050);
      send_word(MODE_UPLOAD, 16'h0003, 16'h0040, 8'h00);
      send_word(MODE_UPLOAD, 16'h0003, 16'h0040, 8'h00);
      send_word(MODE_ABORT, 16'h0000, 16'h0000, 8'h00);
      send_word(MODE_UPLOAD, 16'h0009, 16'h0040, 8'h00);
      send_word(MODE_UPLOAD, 16'h000A, 16'h0040, 8'h00);
      send_word(MODE_UPLOAD, 16'h0000, 16'h0041, 8'h00);
      send_word(MODE_CLRSTATUS, 16'h0000, 16'h0000, 8'h00);
      send_word(MODE_DOWNLOAD, 16'h0000, 16'h0041, 8'h00);
      send_word(MODE_CLRSTATUS, 16'h0000, 16'h0000, 8'h00);
      send_word(MODE_DOWNLOAD, 16'h0000, 16'h0051, 8'h00);
   endtask

   task automatic test_address_wrap();
      write_region(16'hFFFF, 16'hFFFF);
      send_word(MODE_ABORT, 16'h0000, 16'h0000, 8'h00);
      send_word(MODE_DOWNLOAD, 16'h0000, 16'h0040, 8'h00);
      send_word(MODE_DATA, 16'h0000, 16'h0000, 8'h3C);
      send_word(MODE_DATA, 16'h0000, 16'h0000, 8'hC3);
      send_word(MODE_DOWNLOAD, 16'h0001, 16'h000A, 8'h00);
      send_word(MODE_ABORT, 16'h0000, 16'h0000, 8'h00);
      send_word(MODE_UPLOAD, 16'h0002, 16'h0001, 8'h00);
      send_word(MODE_UPLOAD, 16'h0003, 16'h0001, 8'h00);
   endtask

   task automatic leave_error();
      if (dev_state == STATE_ERROR || $urandom_range(0, 3) == 0) begin
         send_word($urandom_range(0, 1) ? MODE_ABORT : MODE_CLRSTATUS, 16'($urandom),
                   16'($urandom), 8'($urandom));
      end
   endtask

   task automatic random_download();
      int nblk;
      int nbytes;
      logic [BLK_W-1:0] blk;
      leave_error();
      blk = 16'($urandom);
      nblk = $urandom_range(1, 5);
      repeat (nblk) begin
         case ($urandom_range(0, 15))
            0: send_word(MODE_DOWNLOAD, want_block - 1'b1, 16'($urandom_range(1, MAX_PACKET)),
                         8'($urandom));
            1: send_word(MODE_DOWNLOAD, blk + 16'($urandom_range(1, 9)), 16'h0001, 8'($urandom));
            default: begin
            end
         endcase
         send_word(MODE_DOWNLOAD, blk, pick_length(), 8'($urandom));
         nbytes = int'(bytes_owed);
         case ($urandom_range(0, 9))
            0: nbytes = $urandom_range(0, nbytes);
            1: nbytes = nbytes + 2;
            default: begin
            end
         endcase
         repeat (nbytes) send_word(MODE_DATA, 16'($urandom), 16'($urandom), 8'($urandom));
         blk = want_block;
      end
      send_word(MODE_DOWNLOAD, want_block, 16'h0000, 8'($urandom));
   endtask

   task automatic random_upload();
      int nblk;
      logic [BLK_W-1:0] blk;
      leave_error();
      blk = 16'($urandom);
      nblk = $urandom_range(1, 8);
      for (int i = 0; i < nblk; i++) begin
         if ($urandom_range(0, 15) == 0) begin
            blk = want_block - 1'b1;
         end
         send_word(MODE_UPLOAD, blk, pick_length(), 8'($urandom));
         if (dev_state != STATE_UPIDLE) begin
            break;
         end
         blk = want_block;
      end
   endtask

   task automatic random_noise();
      repeat ($urandom_range(1, 5)) begin
         send_word(4'($urandom_range(MODE_DETACH, MODE_LAST)), 16'($urandom), 16'($urandom),
                   8'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      int base;
      int pick;
      base = acked_words;
      while (acked_words - base < RANDOM_WORDS) begin
         if (acked_words - base > RANDOM_WORDS - 100) begin
            idle_on = 1'b0;
         end
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 9))
               0: write_region(16'h0000, 16'hFFFF);
               1: write_region(16'hFFFF, 16'hFFFF);
               2: write_region(16'($urandom), 16'h0000);
               default: write_region(16'($urandom & 32'hFE00) - 16'($urandom_range(0, 64)),
                                     16'($urandom_range(64, 1500)));
            endcase
         end
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            random_download();
         end else if (pick < 8) begin
            random_upload();
         end else begin
            random_noise();
         end
      end
   endtask

   initial begin
      region_start = '0;
      region_size = '0;
      dev_state = STATE_IDLE;
      dev_status = STAT_OK;
      want_block = '0;
      flash_cursor = '0;
      bytes_owed = '0;
      dl_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_idle_requests();
      test_download_blocks();
      test_upload_and_limits();
      test_address_wrap();
      test_random_traffic();
      drain_responses();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

endmodule
